FILE: rtl/ssdc_pkg.sv
// Package for the seven-segment display controller: word types, op codes,
// configuration indexes and the character font. No dependencies.

package ssdc_pkg;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_PUT    = 3'd1;
    localparam logic [2:0] OP_CURSOR = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_BLINK  = 3'd4;

    localparam logic [1:0] CFG_LED_VOLTAGE = 2'd0;
    localparam logic [1:0] CFG_LED_CURRENT = 2'd1;
    localparam logic [1:0] CFG_DISPLAY_ON  = 2'd2;

    localparam logic [2:0] BLINK_KEEP_MIN = 3'd4;

    localparam logic [7:0] SEG_H = 8'h20;

    localparam logic [4:0] GLYPH_DEGREE = 5'd28;
    localparam logic [4:0] GLYPH_DASH   = 5'd29;
    localparam logic [4:0] GLYPH_BLANK  = 5'd30;

    localparam logic [7:0] GLYPHS [31] = '{
        8'hD7, 8'h14, 8'hCE, 8'h9E, 8'h1D, 8'h9B, 8'hDB, 8'h16,
        8'hDF, 8'h9F, 8'h5F, 8'hD9, 8'hC8, 8'hDC, 8'hCB, 8'h4B,
        8'hD3, 8'h5D, 8'hC1, 8'h58, 8'hD8, 8'h4F, 8'h48, 8'hC9,
        8'hD0, 8'hD5, 8'h9D, 8'hC3, 8'h0F, 8'h08, 8'h00
    };

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] char_code;
        logic       row_select;
        logic [1:0] column_select;
        logic [2:0] blink_request;
    } t_in_word;

    typedef struct packed {
        logic [2:0] scan_lines;
        logic [7:0] segments_voltage;
        logic [7:0] segments_current;
    } t_out_word;

    typedef struct packed {
        logic led_voltage_mode;
        logic led_current_mode;
        logic display_on;
    } t_cfg;

    function automatic logic [4:0] glyph_index(input logic [6:0] code);
        logic [4:0] idx;
        if (code >= 7'h30 && code <= 7'h39) begin
            idx = 5'(code - 7'h30);
        end else if (code <= 7'h0F) begin
            idx = code[4:0];
        end else begin
            case (code)
                7'h41: idx = 5'h0A;
                7'h62: idx = 5'h0B;
                7'h63: idx = 5'h0C;
                7'h43: idx = 5'h1B;
                7'h64: idx = 5'h0D;
                7'h45: idx = 5'h0E;
                7'h46: idx = 5'h0F;
                7'h47: idx = 5'h10;
                7'h48: idx = 5'h11;
                7'h49: idx = 5'h01;
                7'h4C: idx = 5'h12;
                7'h6E: idx = 5'h13;
                7'h6F: idx = 5'h14;
                7'h4F: idx = 5'h00;
                7'h50: idx = 5'h15;
                7'h72: idx = 5'h16;
                7'h53: idx = 5'h05;
                7'h74: idx = 5'h17;
                7'h75: idx = 5'h18;
                7'h55: idx = 5'h19;
                7'h59: idx = 5'h1A;
                7'h2A: idx = GLYPH_DEGREE;
                7'h20: idx = GLYPH_BLANK;
                default: idx = GLYPH_DASH;
            endcase
        end
        return idx;
    endfunction

    function automatic logic [7:0] char_segments(input logic [7:0] code);
        logic [7:0] seg;
        seg = GLYPHS[glyph_index(code[6:0])];
        if (code[7]) begin
            seg = seg | SEG_H;
        end
        return seg;
    endfunction

endpackage

FILE: rtl/ssdc_in_stage.sv
// Input register stage of the display controller.
// Depends on ssdc_pkg for the input word type.

module ssdc_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ssdc_pkg::t_in_word i_word,
    output logic              o_valid,
    input  logic              i_ready,
    output ssdc_pkg::t_in_word o_word
);

    logic              r_valid;
    ssdc_pkg::t_in_word r_word;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

FILE: rtl/ssdc_core.sv
// Execute stage of the display controller: segment stores, cursor, scan
// phase, blink timer and the result register. Depends on ssdc_pkg.

module ssdc_core #(
    parameter int DIGIT_COUNT  = 3,
    parameter int BLINK_PERIOD = 400,
    parameter int BLINK_HOLD   = 800
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssdc_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  ssdc_pkg::t_in_word  i_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ssdc_pkg::t_out_word o_out_word
);

    localparam int PW      = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int HALF    = BLINK_PERIOD / 2;
    localparam int REM_MAX = (HALF > BLINK_HOLD) ? HALF : BLINK_HOLD;
    localparam int RW      = $clog2(REM_MAX + 1);
    localparam logic [PW-1:0] LAST_DIGIT   = PW'(DIGIT_COUNT - 1);
    localparam logic [RW-1:0] BLINK_RELOAD = RW'(HALF);
    localparam logic [RW-1:0] BLINK_HOLD_V = RW'(BLINK_HOLD);

    logic [7:0]    r_volt [DIGIT_COUNT];
    logic [7:0]    r_curr [DIGIT_COUNT];
    logic          r_row;
    logic [PW-1:0] r_col;
    logic [PW-1:0] r_phase;
    logic [1:0]    r_blink_rows;
    logic          r_vis;
    logic [RW-1:0] r_rem;
    logic          r_out_valid;
    ssdc_pkg::t_out_word r_out;

    logic          n_row;
    logic [PW-1:0] n_col;
    logic [PW-1:0] n_phase;
    logic [1:0]    n_blink_rows;
    logic          n_vis;
    logic [RW-1:0] n_rem;
    ssdc_pkg::t_out_word n_out;

    logic          exec;
    logic          tick_fire;
    logic          put_hit;
    logic          clear_all;
    logic          wr_volt;
    logic          wr_curr;
    logic [7:0]    wr_seg;
    logic [RW-1:0] rem_dec;
    logic [7:0]    dv;
    logic [7:0]    di;

    assign o_ready     = (i_word.op != ssdc_pkg::OP_TICK) || !r_out_valid || i_out_ready;
    assign exec        = i_valid && o_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_row        = r_row;
        n_col        = r_col;
        n_phase      = r_phase;
        n_blink_rows = r_blink_rows;
        n_vis        = r_vis;
        n_rem        = r_rem;
        tick_fire    = 1'b0;
        put_hit      = (r_blink_rows[0] && !r_row) || (r_blink_rows[1] && r_row);
        clear_all    = 1'b0;
        wr_volt      = 1'b0;
        wr_curr      = 1'b0;
        wr_seg       = ssdc_pkg::char_segments(i_word.char_code);
        rem_dec      = (r_rem != '0) ? r_rem - RW'(1) : r_rem;
        dv           = r_volt[r_phase];
        di           = r_curr[r_phase];
        n_out        = '0;
        case (i_word.op)
            ssdc_pkg::OP_TICK: begin
                tick_fire = 1'b1;
                n_rem     = rem_dec;
                if (r_blink_rows != 2'b00) begin
                    if (rem_dec == '0) begin
                        n_rem = BLINK_RELOAD;
                        n_vis = !r_vis;
                    end
                    if (!n_vis) begin
                        if (r_blink_rows[0]) dv = 8'h00;
                        if (r_blink_rows[1]) di = 8'h00;
                    end
                end
                if (r_phase == LAST_DIGIT) begin
                    dv = i_cfg.led_voltage_mode ? (dv | ssdc_pkg::SEG_H)
                                                : (dv & ~ssdc_pkg::SEG_H);
                    di = i_cfg.led_current_mode ? (di | ssdc_pkg::SEG_H)
                                                : (di & ~ssdc_pkg::SEG_H);
                    n_phase = '0;
                end else begin
                    n_phase = r_phase + PW'(1);
                end
                for (int k = 0; k < 3; k++) begin
                    n_out.scan_lines[k] = i_cfg.display_on && (int'(r_phase) == k);
                end
                n_out.segments_voltage = dv;
                n_out.segments_current = di;
            end
            ssdc_pkg::OP_PUT: begin
                if (put_hit) begin
                    n_vis = 1'b1;
                    n_rem = BLINK_HOLD_V;
                end
                wr_volt = !r_row;
                wr_curr = r_row;
                if (r_col == LAST_DIGIT) begin
                    n_col = '0;
                    n_row = !r_row;
                end else begin
                    n_col = r_col + PW'(1);
                end
            end
            ssdc_pkg::OP_CURSOR: begin
                if (int'(i_word.column_select) < DIGIT_COUNT) begin
                    n_row = i_word.row_select;
                    n_col = PW'(i_word.column_select);
                end
            end
            ssdc_pkg::OP_CLEAR: begin
                clear_all = 1'b1;
                n_row     = 1'b0;
                n_col     = '0;
            end
            ssdc_pkg::OP_BLINK: begin
                if (i_word.blink_request < ssdc_pkg::BLINK_KEEP_MIN) begin
                    n_blink_rows = i_word.blink_request[1:0];
                end
                n_rem = BLINK_RELOAD;
                n_vis = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row        <= 1'b0;
            r_col        <= '0;
            r_phase      <= '0;
            r_blink_rows <= 2'b00;
            r_vis        <= 1'b1;
            r_rem        <= '0;
        end else if (exec) begin
            r_row        <= n_row;
            r_col        <= n_col;
            r_phase      <= n_phase;
            r_blink_rows <= n_blink_rows;
            r_vis        <= n_vis;
            r_rem        <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            if (!i_rst_n || (exec && clear_all)) begin
                r_volt[k] <= 8'h00;
                r_curr[k] <= 8'h00;
            end else if (exec && int'(r_col) == k) begin
                if (wr_volt) r_volt[k] <= wr_seg;
                if (wr_curr) r_curr[k] <= wr_seg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec && tick_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec && tick_fire) begin
            r_out <= n_out;
        end
    end

    a_scan_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_out_word.scan_lines))
        else $error("scan lines not one-hot");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_col) < DIGIT_COUNT && int'(r_phase) < DIGIT_COUNT)
        else $error("cursor or scan phase out of range");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && !tick_fire && i_out_ready) |=> !o_out_valid)
        else $error("result without tick");

    a_write_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && i_word.op == ssdc_pkg::OP_PUT && put_hit)
            |=> (r_vis && r_rem == BLINK_HOLD_V))
        else $error("write to blinking row did not hold it on");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> !($past(exec) && $past(tick_fire))
            || $past(o_out_valid && !i_out_ready) == 1'b0)
        else $error("tick executed over a stalled result");

endmodule

FILE: rtl/seven_segment_display_controller_unit.sv
// Top level of the seven-segment display controller: configuration registers,
// input register stage and execute stage. Depends on ssdc_pkg, ssdc_in_stage
// and ssdc_core.
//
// Usage: commands enter as words on the input channel (i_in_valid/o_in_ready).
// Only a tick word makes a result word on the output channel
// (o_out_valid/i_out_ready): one-hot scan lines for the current digit, all low
// while the display is off, and the segments of both rows. Put character, set
// cursor, clear and set blink give no result. Configuration bits are written
// through i_cfg_we/i_cfg_index/i_cfg_data; the user must write them only while
// no command is in flight, which the block itself does not enforce. A tick's
// result passes through the input register, then the result register.
// Throughput: one word per cycle while no tick waits on a stalled result.
// A stalled receiver holds the result register; non-tick words keep flowing,
// and the next tick waits in the input register until the result is taken.
// Reset clears both segment rows, the cursor, the scan phase and blinking,
// and turns the display on.

module seven_segment_display_controller_unit #(
    parameter int DIGIT_COUNT  = 3,
    parameter int BLINK_PERIOD = 400,
    parameter int BLINK_HOLD   = 800
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [0:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ssdc_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ssdc_pkg::t_out_word o_out_word
);

    ssdc_pkg::t_cfg     r_cfg;
    logic               stage_valid;
    logic               stage_ready;
    ssdc_pkg::t_in_word stage_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_voltage_mode <= 1'b0;
            r_cfg.led_current_mode <= 1'b0;
            r_cfg.display_on       <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ssdc_pkg::CFG_LED_VOLTAGE: r_cfg.led_voltage_mode <= i_cfg_data[0];
                ssdc_pkg::CFG_LED_CURRENT: r_cfg.led_current_mode <= i_cfg_data[0];
                ssdc_pkg::CFG_DISPLAY_ON:  r_cfg.display_on       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    ssdc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_word),
        .o_valid (stage_valid),
        .i_ready (stage_ready),
        .o_word  (stage_word)
    );

    ssdc_core #(
        .DIGIT_COUNT  (DIGIT_COUNT),
        .BLINK_PERIOD (BLINK_PERIOD),
        .BLINK_HOLD   (BLINK_HOLD)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (stage_valid),
        .o_ready     (stage_ready),
        .i_word      (stage_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
